### hw/rtl/csp_pkg.sv
package csp_pkg;

	localparam logic signed [63:0] PI_Q30   = 64'sd3373259426;
	localparam logic [30:0]        Q30_ONE  = 31'h4000_0000;
	localparam int                 HORNER_STEPS = 5;
	localparam logic [31:0]        SIN_C11  = 32'd3864;
	localparam logic [31:0]        HORNER_COEF [HORNER_STEPS] = '{
		32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
	};

	typedef enum logic [3:0] {
		REG_MAJOR_RADIUS = 4'd0,
		REG_TUBE_RADIUS  = 4'd1,
		REG_AXIAL_LENGTH = 4'd2,
		REG_TURN_COUNT   = 4'd3
	} cfg_reg_t;

	function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int n);
		logic signed [63:0] half;
		half = 64'sd1 <<< (n - 1);
		return (x + half) >>> n;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] y;
		if (x > 64'sd2147483647) begin
			y = 32'sh7fff_ffff;
		end else if (x < -64'sd2147483648) begin
			y = 32'sh8000_0000;
		end else begin
			y = 32'(x);
		end
		return y;
	endfunction

endpackage

### hw/rtl/csp_if.sv
interface csp_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [23:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

interface csp_param_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] u_param;
	logic signed [17:0] v_angle;
	modport source(output valid, output u_param, output v_angle, input ready);
	modport sink(input valid, input u_param, input v_angle, output ready);
endinterface

interface csp_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] du_x;
	logic signed [31:0] du_y;
	logic signed [31:0] du_z;
	logic signed [31:0] dv_x;
	logic signed [31:0] dv_y;
	modport source(output valid, output pos_x, output pos_y, output pos_z, output du_x,
		output du_y, output du_z, output dv_x, output dv_y, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z, input du_x,
		input du_y, input du_z, input dv_x, input dv_y, output ready);
endinterface

### hw/rtl/csp_qsine.sv
module csp_qsine import csp_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [30:0]        t,
	input  logic               neg,
	output logic signed [31:0] val
);

	logic [30:0] t_s   [0:HORNER_STEPS];
	logic [30:0] t2_s  [0:HORNER_STEPS-1];
	logic        neg_s [0:HORNER_STEPS];
	logic [31:0] acc_s [0:HORNER_STEPS];
	logic [61:0] sq;
	logic [62:0] fin;
	logic [30:0] mag;

	assign sq = 62'(t) * 62'(t);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s[0]   <= t;
			t2_s[0]  <= 31'(sq >> 30);
			neg_s[0] <= neg;
			acc_s[0] <= SIN_C11;
		end
	end

	for (genvar k = 1; k <= HORNER_STEPS; k++) begin : g_horner
		logic [62:0] hp;
		assign hp = 63'(acc_s[k-1]) * 63'(t2_s[k-1]);
		always_ff @(posedge clk) begin
			if (en) begin
				t_s[k]   <= t_s[k-1];
				neg_s[k] <= neg_s[k-1];
				acc_s[k] <= HORNER_COEF[k-1] - 32'(hp >> 30);
			end
		end
		if (k < HORNER_STEPS) begin : g_t2
			always_ff @(posedge clk) begin
				if (en) begin
					t2_s[k] <= t2_s[k-1];
				end
			end
		end
	end

	always_comb begin
		fin = 63'(acc_s[HORNER_STEPS]) * 63'(t_s[HORNER_STEPS]);
		if ((fin >> 30) > 63'(Q30_ONE)) begin
			mag = Q30_ONE;
		end else begin
			mag = 31'(fin >> 30);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val <= neg_s[HORNER_STEPS] ? -32'(mag) : 32'(mag);
		end
	end

endmodule

### hw/rtl/csp_trig.sv
module csp_trig import csp_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	logic [1:0]  qs, qc;
	logic [30:0] fs;
	logic [30:0] ts, tc;
	logic [30:0] t_sin_s, t_cos_s;
	logic        neg_sin_s, neg_cos_s;

	always_comb begin
		qs = phase[31:30];
		qc = phase[31:30] + 2'd1;
		fs = {1'b0, phase[29:0]};
		ts = qs[0] ? (Q30_ONE - fs) : fs;
		tc = qc[0] ? (Q30_ONE - fs) : fs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_sin_s   <= ts;
			t_cos_s   <= tc;
			neg_sin_s <= qs[1];
			neg_cos_s <= qc[1];
		end
	end

	csp_qsine u_sin (.clk(clk), .en(en), .t(t_sin_s), .neg(neg_sin_s), .val(sin_val));
	csp_qsine u_cos (.clk(clk), .en(en), .t(t_cos_s), .neg(neg_cos_s), .val(cos_val));

endmodule

### hw/rtl/corkscrew_surface_point_eval_unit.sv
// Triple corkscrew surface point and tangent unit.
// Throughput: one word per cycle; the whole pipeline holds while the output stalls.
// Depth is set by the sine units: a quadrant fold, Horner multiply stages and a scale.
// Reset clears the valid bits and loads the default radii, length and turn count.
module corkscrew_surface_point_eval_unit import csp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	csp_cfg_if.sink     cfg,
	csp_param_if.sink   param,
	csp_point_if.source point
);

	localparam int LAST = 14;
	localparam int AW   = 23 + ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2 - FRAC_BITS;
	localparam int ACW  = AW + 1;
	localparam int XW   = AW + 3;
	localparam int LW   = 43 - FRAC_BITS;
	localparam int PW   = 26;
	localparam int BW   = 26;
	localparam int TW   = 27;
	localparam int P1W  = 52 - FRAC_BITS;
	localparam int SH   = 2 * FRAC_BITS - 31;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

	typedef struct packed {
		logic signed [AW-1:0] a;
		logic signed [LW-1:0] lz;
		logic signed [1:0]    sgn;
		logic signed [PW-1:0] pir;
	} side_t;

	logic signed [23:0] major_radius_q, tube_radius_q, axial_length_q, turn_count_q;
	logic [LAST:1]      vld_s;
	logic               adv;

	assign adv         = !vld_s[LAST] || point.ready;
	assign param.ready = adv;
	assign cfg.ready   = 1'b1;
	assign point.valid = vld_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_radius_q <= 24'sd98304;
			tube_radius_q  <= 24'sd32768;
			axial_length_q <= 24'sd65536;
			turn_count_q   <= 24'sd65536;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_MAJOR_RADIUS: major_radius_q <= cfg.data;
				REG_TUBE_RADIUS:  tube_radius_q  <= cfg.data;
				REG_AXIAL_LENGTH: axial_length_q <= cfg.data;
				REG_TURN_COUNT:   turn_count_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAST-1:1], param.valid};
		end
	end

	// stage 1: turn product, tube size, axial position, scaled radius
	logic signed [63:0] u_ext, absu_ext;
	logic signed [17:0] u_s1, v_s1;
	logic signed [41:0] prod_s1;
	side_t              side_s [1:10];
	side_t              side_in;

	always_comb begin
		u_ext       = 64'(param.u_param);
		absu_ext    = (u_ext < 0) ? -u_ext : u_ext;
		side_in.a   = AW'(rnd(64'(tube_radius_q) * (ONE - absu_ext), FRAC_BITS));
		side_in.lz  = LW'(rnd(64'(axial_length_q) * u_ext, FRAC_BITS));
		side_in.sgn = (u_ext > 0) ? 2'sd1 : ((u_ext < 0) ? -2'sd1 : 2'sd0);
		side_in.pir = PW'(rnd(64'(major_radius_q) * PI_Q30, 30));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1      <= param.u_param;
			v_s1      <= param.v_angle;
			prod_s1   <= 42'(u_ext * 64'(turn_count_q));
			side_s[1] <= side_in;
		end
	end

	for (genvar k = 2; k <= 10; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// stage 2: phases
	logic [31:0] ph_n;
	logic [31:0] ph_v_s2, ph_u_s2, ph_n_s2;

	if (SH >= 0) begin : g_phn_down
		assign ph_n = 32'(64'(prod_s1) >>> SH);
	end else begin : g_phn_up
		assign ph_n = 32'(64'(prod_s1) <<< (-SH));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_v_s2 <= 32'(32'(v_s1) <<< (31 - FRAC_BITS));
			ph_u_s2 <= 32'(32'(u_s1) <<< (30 - FRAC_BITS));
			ph_n_s2 <= ph_n;
		end
	end

	// stages 3 to 10: sine and cosine
	logic signed [31:0] sv, cv, su, cu, sn, cn;

	csp_trig u_trig_v (.clk(clk), .en(adv), .phase(ph_v_s2), .sin_val(sv), .cos_val(cv));
	csp_trig u_trig_u (.clk(clk), .en(adv), .phase(ph_u_s2), .sin_val(su), .cos_val(cu));
	csp_trig u_trig_n (.clk(clk), .en(adv), .phase(ph_n_s2), .sin_val(sn), .cos_val(cn));

	// stage 11: first products
	logic signed [BW-1:0]  b_s11, rc_s11, rs_s11;
	logic signed [31:0]    m1_s11, m2_s11, m3_s11, m4_s11, cn_s11, sn_s11;
	logic signed [ACW-1:0] ac_s11, as_s11, nas_s11;
	side_t                 side_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s11    <= BW'(rnd(64'(major_radius_q) * 64'(cu), 30));
			m1_s11   <= 32'(rnd(64'(cu) * 64'(sn), 30));
			m2_s11   <= 32'(rnd(64'(cn) * 64'(su), 31));
			m3_s11   <= 32'(rnd(64'(cu) * 64'(cn), 30));
			m4_s11   <= 32'(rnd(64'(sn) * 64'(su), 31));
			ac_s11   <= ACW'(rnd(64'(side_s[10].a) * 64'(cv), 30));
			as_s11   <= ACW'(rnd(64'(side_s[10].a) * 64'(sv), 30));
			nas_s11  <= ACW'(rnd(-(64'(side_s[10].a) * 64'(sv)), 30));
			rc_s11   <= BW'(rnd(64'(tube_radius_q) * 64'(cv), 30));
			rs_s11   <= BW'(rnd(64'(tube_radius_q) * 64'(sv), 30));
			cn_s11   <= cn;
			sn_s11   <= sn;
			side_s11 <= side_s[10];
		end
	end

	// stage 12: second products
	logic signed [TW-1:0]  bc_s12, bs_s12, t1_s12, p2_s12, t3_s12, q2_s12;
	logic signed [ACW-1:0] ac_s12, as_s12, nas_s12;
	logic signed [BW-1:0]  rc_s12, rs_s12;
	logic signed [LW-1:0]  lz_s12;
	logic signed [1:0]     sgn_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			bc_s12  <= TW'(rnd(64'(b_s11) * 64'(cn_s11), 30));
			bs_s12  <= TW'(rnd(64'(b_s11) * 64'(sn_s11), 30));
			t1_s12  <= TW'(rnd(64'(side_s11.pir) * 64'(m1_s11), 30));
			p2_s12  <= TW'(rnd(64'(side_s11.pir) * 64'(m2_s11), 30));
			t3_s12  <= TW'(rnd(64'(side_s11.pir) * 64'(m3_s11), 30));
			q2_s12  <= TW'(rnd(64'(side_s11.pir) * 64'(m4_s11), 30));
			ac_s12  <= ac_s11;
			as_s12  <= as_s11;
			nas_s12 <= nas_s11;
			rc_s12  <= rc_s11;
			rs_s12  <= rs_s11;
			lz_s12  <= side_s11.lz;
			sgn_s12 <= side_s11.sgn;
		end
	end

	// stage 13: turn count scaling and point sums
	logic signed [P1W-1:0] p1_s13, q1_s13;
	logic signed [XW-1:0]  x_s13, y_s13;
	logic signed [TW-1:0]  p2_s13, q2_s13;
	logic signed [ACW-1:0] ac_s13, nas_s13;
	logic signed [BW-1:0]  rc_s13, rs_s13;
	logic signed [LW-1:0]  lz_s13;
	logic signed [1:0]     sgn_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s13  <= P1W'(rnd(64'(t1_s12) * 64'(turn_count_q), FRAC_BITS));
			q1_s13  <= P1W'(rnd(64'(t3_s12) * 64'(turn_count_q), FRAC_BITS));
			x_s13   <= XW'(64'(ac_s12) + 64'(bc_s12));
			y_s13   <= XW'(64'(as_s12) + 64'(bs_s12));
			p2_s13  <= p2_s12;
			q2_s13  <= q2_s12;
			ac_s13  <= ac_s12;
			nas_s13 <= nas_s12;
			rc_s13  <= rc_s12;
			rs_s13  <= rs_s12;
			lz_s13  <= lz_s12;
			sgn_s13 <= sgn_s12;
		end
	end

	// stage 14: tube slope terms and saturation
	logic signed [63:0] rcs, rss;

	always_comb begin
		if (sgn_s13 > 2'sd0) begin
			rcs = 64'(rc_s13);
			rss = 64'(rs_s13);
		end else if (sgn_s13 < 2'sd0) begin
			rcs = -64'(rc_s13);
			rss = -64'(rs_s13);
		end else begin
			rcs = 64'sd0;
			rss = 64'sd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point.pos_x <= sat32(64'(x_s13));
			point.pos_y <= sat32(64'(y_s13));
			point.pos_z <= sat32(64'(lz_s13));
			point.du_x  <= sat32(-(64'(p1_s13) + 64'(p2_s13)) - rcs);
			point.du_y  <= sat32((64'(q1_s13) - 64'(q2_s13)) - rss);
			point.du_z  <= sat32(64'(axial_length_q));
			point.dv_x  <= sat32(64'(nas_s13));
			point.dv_y  <= sat32(64'(ac_s13));
		end
	end

	ap_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> vld_s == $past(vld_s))
		else $error("pipeline valid bits moved during a stall");

	ap_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		param.valid && param.ready |=> vld_s[1])
		else $error("accepted word did not enter stage one");

	ap_du_z_length: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid |-> point.du_z == 32'(axial_length_q))
		else $error("du_z differs from axial length");

endmodule
